// ===== rtl/core/frm_pkg.sv =====
package frm_pkg;

	localparam int EXP_TABLE_DEPTH_DEF = 256;

	localparam int TS_W       = 32;
	localparam int RATE_W     = 28;
	localparam int TAU_W      = 26;
	localparam int MAXI_W     = 20;
	localparam int ALPHA_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 26;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 88;
	localparam int INST_NUM_W = 29;

	localparam logic [TAU_W-1:0]      TAU_RESET  = 26'd700000;
	localparam logic [TAU_W-1:0]      TAU_MIN    = 26'd10000;
	localparam logic [MAXI_W-1:0]     MAXI_RESET = 20'd250000;
	localparam logic [INST_NUM_W-1:0] INST_SCALE = 29'd256000000;
	localparam logic [RATE_W-1:0]     RATE_MAX   = 28'hFFFFFFF;
	localparam logic [31:0]           EXP_NEG1_Q32 = 32'd1580030169;

	localparam logic [CFG_IDX_W-1:0] REG_TAU          = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 1'd1;

	localparam logic [1:0] MUL_W_RATE = 2'd0;
	localparam logic [1:0] MUL_A_INST = 2'd1;
	localparam logic [1:0] MUL_W_TIME = 2'd2;
	localparam logic [1:0] MUL_A_FT   = 2'd3;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	typedef struct packed {
		logic       take;
		logic       commit_prev;
		logic       load_dt;
		logic       div_start;
		logic       div_pos;
		logic       load_inst;
		logic       load_pos;
		logic       rom_hi;
		logic       load_lo;
		logic       load_alpha;
		logic       seed;
		logic [1:0] mul_op;
		logic [1:0] acc_op;
		logic       wb_rate;
		logic       wb_time;
		logic       emit;
		logic       emit_upd;
	} frm_cmd_t;

	typedef struct packed {
		logic skip;
		logic seeded;
		logic div_done;
		logic out_free;
	} frm_status_t;

	// shift-subtract quotient, used only when building the alpha table
	function automatic logic [63:0] frm_div_small(input logic [63:0] num, input logic [5:0] den);
		logic [6:0]  rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[5:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// alpha = 1 - exp(-x) in Q0.16, x given in Q32.32
	function automatic logic [15:0] frm_alpha_entry(input logic [63:0] xq);
		logic [4:0]         n;
		logic [31:0]        f;
		logic [95:0]        prod;
		logic [63:0]        term;
		logic signed [67:0] sum;
		logic [63:0]        v;
		logic [95:0]        vp;
		logic [63:0]        a;
		n    = xq[36:32];
		f    = xq[31:0];
		sum  = 68'sh1_0000_0000;
		term = 64'h1_0000_0000;
		for (int k = 1; k <= 40; k++) begin
			prod = {32'b0, term} * {64'b0, f};
			term = frm_div_small(prod[95:32], 6'(k));
			if ((k & 1) == 1)
				sum = sum - $signed({4'b0, term});
			else
				sum = sum + $signed({4'b0, term});
		end
		if (sum < 0)
			sum = '0;
		if (sum > 68'sh1_0000_0000)
			sum = 68'sh1_0000_0000;
		v = sum[63:0];
		for (int j = 0; j < 16; j++) begin
			if (j < int'(n)) begin
				vp = {32'b0, v} * {64'b0, EXP_NEG1_Q32};
				v  = vp[95:32];
			end
		end
		a = (64'h1_0000_0000 - v + 64'h8000) >> 16;
		if (a > 64'd65535)
			a = 64'd65535;
		return a[15:0];
	endfunction

endpackage

// ===== rtl/core/frm_divider.sv =====
module frm_divider #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= denom;
			rem_q  <= '0;
			quot_q <= numer;
		end else if (busy_q) begin
			if (fits)
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/core/frm_datapath.sv =====
module frm_datapath #(
	parameter int EXP_TABLE_DEPTH = frm_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [frm_pkg::IN_TDATA_W-1:0]  in_data,
	input  frm_pkg::frm_cmd_t               cmd,
	output frm_pkg::frm_status_t            status,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            out_user,
	output logic [frm_pkg::OUT_TDATA_W-1:0] out_data
);
	import frm_pkg::*;

	localparam int MUL_K  = EXP_TABLE_DEPTH * 16;
	localparam int KW     = $clog2(MUL_K + 1);
	localparam int POS_NW = MAXI_W + KW;
	localparam int DIV_W  = (POS_NW > INST_NUM_W) ? POS_NW : INST_NUM_W;
	localparam int IW     = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IDX_FW = DIV_W - 8;

	logic [TAU_W-1:0]   tau_q;
	logic [MAXI_W-1:0]  maxi_q;
	logic [TS_W-1:0]    now_q;
	logic [TS_W-1:0]    prev_q;
	logic               have_prev_q;
	logic               seeded_q;
	logic [MAXI_W-1:0]  dt_q;
	logic [RATE_W-1:0]  inst_q;
	logic [RATE_W-1:0]  srate_q;
	logic [RATE_W-1:0]  stime_q;
	logic [DIV_W-1:0]   pos_q;
	logic [ALPHA_W-1:0] rom_q;
	logic [ALPHA_W-1:0] lo_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [44:0]        prod_s1;
	logic [44:0]        acc_q;
	logic               out_valid_q;
	logic               out_upd_q;
	logic [RATE_W-1:0]  out_inst_q;
	logic [RATE_W-1:0]  out_srate_q;
	logic [RATE_W-1:0]  out_stime_q;

	logic [TAU_W-1:0]   tau_eff;
	logic [MAXI_W-1:0]  lim;
	logic [TS_W-1:0]    dt_raw;
	logic [MAXI_W-1:0]  dt_clamp;
	logic [RATE_W-1:0]  ft;
	logic [DIV_W-1:0]   inst_num;
	logic [DIV_W-1:0]   pos_num;
	logic [DIV_W-1:0]   div_numer;
	logic [TAU_W-1:0]   div_denom;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;
	logic [IDX_FW-1:0]  idx_full;
	logic               idx_sat;
	logic [IW-1:0]      idx_lo;
	logic [IW-1:0]      idx_hi;
	logic [IW-1:0]      rom_addr;
	logic [ALPHA_W-1:0] hi_fix;
	logic [23:0]        interp;
	logic [16:0]        alpha_sum;
	logic [16:0]        mul_a;
	logic [RATE_W-1:0]  mul_b;
	logic [44:0]        round_sum;
	logic [RATE_W:0]    ema_raw;
	logic [RATE_W-1:0]  ema_val;
	logic               out_free;

	logic [ALPHA_W-1:0] rom_tbl [0:EXP_TABLE_DEPTH];

	for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [63:0] XQ = (64'(g) << 36) / EXP_TABLE_DEPTH;
		assign rom_tbl[g] = frm_alpha_entry(XQ);
	end

	assign tau_eff  = (tau_q < TAU_MIN) ? TAU_MIN : tau_q;
	assign lim      = (maxi_q == '0) ? MAXI_W'(1) : maxi_q;
	assign dt_raw   = now_q - prev_q;
	assign dt_clamp = (dt_raw > TS_W'(lim)) ? lim : dt_raw[MAXI_W-1:0];
	assign ft       = {dt_q, 8'b0};

	assign inst_num  = DIV_W'(INST_SCALE) + DIV_W'(dt_q >> 1);
	assign pos_num   = DIV_W'(dt_q) * DIV_W'(MUL_K);
	assign div_numer = cmd.div_pos ? pos_num : inst_num;
	assign div_denom = cmd.div_pos ? tau_eff : TAU_W'(dt_q);

	frm_divider #(
		.NUM_W(DIV_W),
		.DEN_W(TAU_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.numer (div_numer),
		.denom (div_denom),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign idx_full = pos_q[DIV_W-1:8];
	assign idx_sat  = idx_full >= IDX_FW'(EXP_TABLE_DEPTH);
	assign idx_lo   = idx_sat ? IW'(EXP_TABLE_DEPTH) : idx_full[IW-1:0];
	assign idx_hi   = idx_sat ? IW'(EXP_TABLE_DEPTH) : IW'(idx_full[IW-1:0] + 1'b1);
	assign rom_addr = cmd.rom_hi ? idx_hi : idx_lo;

	assign hi_fix    = (rom_q < lo_q) ? lo_q : rom_q;
	assign interp    = (hi_fix - lo_q) * pos_q[7:0];
	assign alpha_sum = {1'b0, lo_q} + {1'b0, interp[23:8]};

	always_comb begin
		unique case (cmd.mul_op)
			MUL_W_RATE: begin
				mul_a = 17'h10000 - {1'b0, alpha_q};
				mul_b = srate_q;
			end
			MUL_A_INST: begin
				mul_a = {1'b0, alpha_q};
				mul_b = inst_q;
			end
			MUL_W_TIME: begin
				mul_a = 17'h10000 - {1'b0, alpha_q};
				mul_b = stime_q;
			end
			MUL_A_FT: begin
				mul_a = {1'b0, alpha_q};
				mul_b = ft;
			end
		endcase
	end

	assign round_sum = acc_q + 45'd32768;
	assign ema_raw   = round_sum[44:16];
	assign ema_val   = ema_raw[RATE_W] ? RATE_MAX : ema_raw[RATE_W-1:0];

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q       <= TAU_RESET;
			maxi_q      <= MAXI_RESET;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			seeded_q    <= 1'b0;
			inst_q      <= '0;
			srate_q     <= '0;
			stime_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TAU)
					tau_q <= cfg_data[TAU_W-1:0];
				else if (cfg_index == REG_MAX_INTERVAL)
					maxi_q <= cfg_data[MAXI_W-1:0];
			end
			if (cmd.commit_prev) begin
				prev_q      <= now_q;
				have_prev_q <= 1'b1;
			end
			if (cmd.load_inst)
				inst_q <= (div_quot > DIV_W'(RATE_MAX)) ? RATE_MAX : div_quot[RATE_W-1:0];
			if (cmd.seed) begin
				srate_q  <= inst_q;
				stime_q  <= ft;
				seeded_q <= 1'b1;
			end
			if (cmd.wb_rate)
				srate_q <= ema_val;
			if (cmd.wb_time)
				stime_q <= ema_val;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			now_q <= in_data[TS_W-1:0];
		if (cmd.load_dt)
			dt_q <= dt_clamp;
		if (cmd.load_pos)
			pos_q <= div_quot;
		rom_q <= rom_tbl[rom_addr];
		if (cmd.load_lo)
			lo_q <= rom_q;
		if (cmd.load_alpha)
			alpha_q <= alpha_sum[ALPHA_W-1:0];
		prod_s1 <= mul_a * mul_b;
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_s1;
			ACC_ADD:  acc_q <= acc_q + prod_s1;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.emit) begin
			out_upd_q   <= cmd.emit_upd;
			out_inst_q  <= inst_q;
			out_srate_q <= srate_q;
			out_stime_q <= stime_q;
		end
	end

	assign status.skip     = !have_prev_q || (now_q == prev_q);
	assign status.seeded   = seeded_q;
	assign status.div_done = div_done;
	assign status.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_user  = out_upd_q;
	assign out_data  = {4'b0, out_stime_q, out_srate_q, out_inst_q};

endmodule

// ===== rtl/core/frm_ctrl.sv =====
module frm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  frm_pkg::frm_status_t status,
	output frm_pkg::frm_cmd_t    cmd
);
	import frm_pkg::*;

	localparam logic [4:0] ST_IDLE       = 5'd0;
	localparam logic [4:0] ST_CHECK      = 5'd1;
	localparam logic [4:0] ST_START_INST = 5'd2;
	localparam logic [4:0] ST_WAIT_INST  = 5'd3;
	localparam logic [4:0] ST_SEED       = 5'd4;
	localparam logic [4:0] ST_START_POS  = 5'd5;
	localparam logic [4:0] ST_WAIT_POS   = 5'd6;
	localparam logic [4:0] ST_ROM_LO     = 5'd7;
	localparam logic [4:0] ST_ROM_HI     = 5'd8;
	localparam logic [4:0] ST_ALPHA      = 5'd9;
	localparam logic [4:0] ST_MAC1       = 5'd10;
	localparam logic [4:0] ST_MAC2       = 5'd11;
	localparam logic [4:0] ST_MAC3       = 5'd12;
	localparam logic [4:0] ST_MAC4       = 5'd13;
	localparam logic [4:0] ST_MAC5       = 5'd14;
	localparam logic [4:0] ST_MAC6       = 5'd15;
	localparam logic [4:0] ST_EMIT_SKIP  = 5'd16;
	localparam logic [4:0] ST_EMIT_UPD   = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.commit_prev = 1'b1;
				cmd.load_dt     = 1'b1;
				state_d = status.skip ? ST_EMIT_SKIP : ST_START_INST;
			end
			ST_START_INST: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT_INST;
			end
			ST_WAIT_INST: begin
				if (status.div_done) begin
					cmd.load_inst = 1'b1;
					state_d = status.seeded ? ST_START_POS : ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d  = ST_EMIT_UPD;
			end
			ST_START_POS: begin
				cmd.div_start = 1'b1;
				cmd.div_pos   = 1'b1;
				state_d       = ST_WAIT_POS;
			end
			ST_WAIT_POS: begin
				cmd.div_pos = 1'b1;
				if (status.div_done) begin
					cmd.load_pos = 1'b1;
					state_d      = ST_ROM_LO;
				end
			end
			ST_ROM_LO: begin
				state_d = ST_ROM_HI;
			end
			ST_ROM_HI: begin
				cmd.rom_hi  = 1'b1;
				cmd.load_lo = 1'b1;
				state_d     = ST_ALPHA;
			end
			ST_ALPHA: begin
				cmd.load_alpha = 1'b1;
				state_d        = ST_MAC1;
			end
			ST_MAC1: begin
				cmd.mul_op = MUL_W_RATE;
				state_d    = ST_MAC2;
			end
			ST_MAC2: begin
				cmd.mul_op = MUL_A_INST;
				cmd.acc_op = ACC_LOAD;
				state_d    = ST_MAC3;
			end
			ST_MAC3: begin
				cmd.mul_op = MUL_W_TIME;
				cmd.acc_op = ACC_ADD;
				state_d    = ST_MAC4;
			end
			ST_MAC4: begin
				cmd.mul_op  = MUL_A_FT;
				cmd.acc_op  = ACC_LOAD;
				cmd.wb_rate = 1'b1;
				state_d     = ST_MAC5;
			end
			ST_MAC5: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_MAC6;
			end
			ST_MAC6: begin
				cmd.wb_time = 1'b1;
				state_d     = ST_EMIT_UPD;
			end
			ST_EMIT_SKIP: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_EMIT_UPD: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_upd = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/frame_rate_ema_meter_top.sv =====
// Frame rate meter with exponential moving averages.
// s_axis carries one frame-start timestamp in microseconds per transaction;
// m_axis returns one result per accepted timestamp: tuser is the updated flag,
// tdata holds instant rate, smoothed rate and smoothed frame time (Q20.8).
// cfg_we/cfg_index/cfg_data write tau_us (index 0) and max_interval_us
// (index 1); write them only while the block is idle.
// The first timestamp and a repeated one bypass the divider; otherwise the
// bit-serial divider is used once for the instant rate and, once the
// averages are seeded, once more for the table position.
// One timestamp is processed at a time; the next is accepted as soon as the
// result is in the output register.
// Reset clears the previous time and the averages and restores the register
// defaults. If m_axis_tready is low the result holds in the output register;
// a following item is processed but not emitted until that slot frees.
module frame_rate_ema_meter_top #(
	parameter int EXP_TABLE_DEPTH = frm_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [frm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // timestamp_us
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// instant_rate, smoothed_rate, smoothed_frame_time, 4 pad bits
	output logic [frm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tuser   // updated
);
	import frm_pkg::*;

	frm_cmd_t    cmd;
	frm_status_t status;

	frm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	frm_datapath #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.status   (status),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_user (m_axis_tuser),
		.out_data (m_axis_tdata)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import frm_pkg::*;

	localparam int TAB_DEPTH      = EXP_TABLE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RX_HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES  = 20;
	localparam int END_CYCLES     = 200;
	localparam int NUM_PHASES     = 8;
	localparam int NUM_FIXED      = 6;
	localparam int HOLD_PHASE     = 6;
	localparam int PHASE_ITEMS    = 250;
	localparam int NUM_DIR        = 19;

	typedef struct packed {
		logic              upd;
		logic [RATE_W-1:0] inst;
		logic [RATE_W-1:0] srate;
		logic [RATE_W-1:0] stime;
	} meter_res_t;

	typedef struct packed {
		logic [TS_W-1:0] stamp;
		logic            typed;
		meter_res_t      res;
	} stamp_row_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // instant_rate, smoothed_rate, smoothed_frame_time, pad
	logic                   m_axis_tuser;  // updated

	frame_rate_ema_meter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// predictor state
	logic [15:0]       alpha_tab [0:TAB_DEPTH];
	logic [TAU_W-1:0]  tau_cfg;
	logic [MAXI_W-1:0] maxi_cfg;
	logic [TS_W-1:0]   prev_stamp;
	logic              have_prev;
	logic              seeded;
	logic [RATE_W-1:0] inst_q;
	logic [RATE_W-1:0] srate_q;
	logic [RATE_W-1:0] stime_q;

	meter_res_t rate_results_q [$];
	meter_res_t got_res;
	meter_res_t exp_res;

	int  err_cnt      = 0;
	int  checked_cnt  = 0;
	int  updated_cnt  = 0;
	int  sent_cnt     = 0;
	int  idle_cycles  = 0;
	int  burst_left   = 1;
	bit  tx_gaps      = 1'b1;
	bit  hold_req     = 1'b0;
	int  stall_left   = 0;
	int  seg_left     = 0;
	bit  rx_stalls    = 1'b0;

	stamp_row_t dir_rows [NUM_DIR] = '{
		'{32'h0000_0000, 1'b1, '{1'b0, 28'd0, 28'd0, 28'd0}},
		'{32'h0000_0000, 1'b1, '{1'b0, 28'd0, 28'd0, 28'd0}},
		'{32'h0000_0001, 1'b1, '{1'b1, 28'd256000000, 28'd256000000, 28'd256}},
		'{32'h0000_0001, 1'b1, '{1'b0, 28'd256000000, 28'd256000000, 28'd256}},
		'{32'h0000_0000, 1'b0, '0},
		'{32'hFFFF_FFFF, 1'b0, '0},
		'{32'hFFFF_FFF0, 1'b0, '0},
		'{32'h0000_0010, 1'b0, '0},
		'{32'h0000_0010, 1'b0, '0},
		'{32'h0000_4123, 1'b0, '0},
		'{32'h0000_8246, 1'b0, '0},
		'{32'h0004_52D6, 1'b0, '0},
		'{32'h0008_2367, 1'b0, '0},
		'{32'h0008_2368, 1'b0, '0},
		'{32'hAAAA_AAAA, 1'b0, '0},
		'{32'h5555_5555, 1'b0, '0},
		'{32'h5555_5556, 1'b0, '0},
		'{32'h7FFF_FFFF, 1'b0, '0},
		'{32'h8000_0000, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// alpha = 1 - exp(-x), x = 16*i/depth, Q0.16
	function automatic void build_alpha_tab();
		longint unsigned xq, n, f, term, v, a;
		longint          acc;
		for (int i = 0; i <= TAB_DEPTH; i++) begin
			xq   = (64'(i) << 36) / 64'(TAB_DEPTH);
			n    = xq >> 32;
			f    = xq & 64'hFFFF_FFFF;
			acc  = 64'sh1_0000_0000;
			term = 64'h1_0000_0000;
			for (int k = 1; k <= 40; k++) begin
				term = ((term * f) >> 32) / 64'(k);
				if (k % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > 64'sh1_0000_0000)
				acc = 64'sh1_0000_0000;
			v = longint'(acc);
			for (longint unsigned j = 0; j < n; j++)
				v = (v * 64'(EXP_NEG1_Q32)) >> 32;
			a = (64'h1_0000_0000 - v + 64'h8000) >> 16;
			if (a > 64'd65535)
				a = 64'd65535;
			alpha_tab[i] = a[15:0];
		end
	endfunction

	function automatic logic [15:0] alpha_for(input logic [31:0] dt, input logic [TAU_W-1:0] tau);
		longint unsigned pos, idx, r, lo, hi;
		pos = (64'(dt) * 64'(TAB_DEPTH) * 64'd16) / 64'(tau);
		idx = pos >> 8;
		r   = pos & 64'hFF;
		if (idx >= 64'(TAB_DEPTH))
			return alpha_tab[TAB_DEPTH];
		lo = 64'(alpha_tab[idx]);
		hi = 64'(alpha_tab[idx + 1]);
		if (hi < lo)
			hi = lo;
		return 16'(lo + (((hi - lo) * r) >> 8));
	endfunction

	function automatic logic [RATE_W-1:0] ema_blend(input logic [RATE_W-1:0] old_v,
			input logic [RATE_W-1:0] sample, input logic [15:0] a);
		longint unsigned v;
		v = ((64'd65536 - 64'(a)) * 64'(old_v) + 64'(a) * 64'(sample) + 64'd32768) >> 16;
		if (v > 64'(RATE_MAX))
			v = 64'(RATE_MAX);
		return v[RATE_W-1:0];
	endfunction

	function automatic meter_res_t predict_frame(input logic [TS_W-1:0] stamp);
		logic [31:0]      dt, lim;
		logic [TAU_W-1:0] tau_eff;
		longint unsigned  inst, ft;
		logic [15:0]      a;
		meter_res_t       r;
		r = '0;
		if (have_prev) begin
			dt = stamp - prev_stamp;
			if (dt != 0) begin
				lim     = (maxi_cfg == 0) ? 32'd1 : 32'(maxi_cfg);
				tau_eff = (tau_cfg < TAU_MIN) ? TAU_MIN : tau_cfg;
				if (dt > lim)
					dt = lim;
				inst = (64'(INST_SCALE) + 64'(dt >> 1)) / 64'(dt);
				if (inst > 64'(RATE_MAX))
					inst = 64'(RATE_MAX);
				ft = 64'(dt) << 8;
				if (ft > 64'(RATE_MAX))
					ft = 64'(RATE_MAX);
				inst_q = inst[RATE_W-1:0];
				if (!seeded) begin
					srate_q = inst[RATE_W-1:0];
					stime_q = ft[RATE_W-1:0];
					seeded  = 1'b1;
				end else begin
					a       = alpha_for(dt, tau_eff);
					srate_q = ema_blend(srate_q, inst[RATE_W-1:0], a);
					stime_q = ema_blend(stime_q, ft[RATE_W-1:0], a);
				end
				r.upd = 1'b1;
			end
		end
		prev_stamp = stamp;
		have_prev  = 1'b1;
		r.inst     = inst_q;
		r.srate    = srate_q;
		r.stime    = stime_q;
		return r;
	endfunction

	function automatic logic [TS_W-1:0] next_stamp(input logic [TS_W-1:0] prev);
		int unsigned lim, pick;
		lim  = (maxi_cfg == 0) ? 1 : int'(maxi_cfg);
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return prev;
		else if (pick < 10)
			return $urandom();
		else if (pick < 15)
			return prev + $urandom_range(1, 16);
		else if (pick < 60)
			return prev + $urandom_range(1, lim + lim / 4 + 1);
		else if (pick < 80)
			return prev + $urandom_range(4000, 70000);
		else if (pick < 95)
			return prev + $urandom_range(1000000, 100000000);
		else
			return prev - $urandom_range(1, 1000);
	endfunction

	// caller runs at a clock edge; tvalid stays high across a burst
	task automatic send_stamp(input logic [TS_W-1:0] stamp);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= stamp;
		do @(posedge clk); while (!s_axis_tready);
		sent_cnt++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (tx_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 40) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drive_stamp(input logic [TS_W-1:0] stamp);
		rate_results_q.push_back(predict_frame(stamp));
		send_stamp(stamp);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (rate_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [TAU_W-1:0] tau, input logic [MAXI_W-1:0] maxi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TAU;
		cfg_data  <= CFG_DATA_W'(tau);
		@(posedge clk);
		cfg_index <= REG_MAX_INTERVAL;
		cfg_data  <= CFG_DATA_W'(maxi);
		@(posedge clk);
		cfg_we <= 1'b0;
		tau_cfg  = tau;
		maxi_cfg = maxi;
		@(posedge clk);
	endtask

	// receiver: random stall segments, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left  = $urandom_range(50, 1500);
					rx_stalls = ($urandom_range(0, 2) != 0);
				end else begin
					seg_left--;
				end
				if (stall_left != 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
					if (rx_stalls && $urandom_range(0, 9) < 2)
						stall_left = $urandom_range(1, 25);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got_res = '{m_axis_tuser, m_axis_tdata[27:0], m_axis_tdata[55:28],
				m_axis_tdata[83:56]};
			checked_cnt++;
			if (got_res.upd)
				updated_cnt++;
			if (rate_results_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result: upd=%0d inst=%0h srate=%0h stime=%0h",
						got_res.upd, got_res.inst, got_res.srate, got_res.stime);
			end else begin
				exp_res = rate_results_q.pop_front();
				if (got_res !== exp_res) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"mismatch at result %0d: exp upd=%0d inst=%0h srate=%0h ",
							"stime=%0h, got upd=%0d inst=%0h srate=%0h stime=%0h"},
							checked_cnt, exp_res.upd, exp_res.inst, exp_res.srate,
							exp_res.stime, got_res.upd, got_res.inst, got_res.srate,
							got_res.stime);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		logic [TAU_W-1:0]  ph_tau  [NUM_PHASES];
		logic [MAXI_W-1:0] ph_maxi [NUM_PHASES];
		logic [TS_W-1:0]   stamp;

		ph_tau  = '{TAU_RESET, 26'd10000, 26'd60000000, 26'h3FFFFFF, 26'd9999, 26'd0,
			26'd0, 26'd0};
		ph_maxi = '{MAXI_RESET, 20'd1000000, 20'd1, 20'd0, 20'hFFFFF, 20'd33333,
			20'd0, 20'd0};

		tau_cfg    = TAU_RESET;
		maxi_cfg   = MAXI_RESET;
		prev_stamp = '0;
		have_prev  = 1'b0;
		seeded     = 1'b0;
		inst_q     = '0;
		srate_q    = '0;
		stime_q    = '0;
		build_alpha_tab();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings
		for (int i = 0; i < NUM_DIR; i++) begin
			exp_res = predict_frame(dir_rows[i].stamp);
			rate_results_q.push_back(dir_rows[i].typed ? dir_rows[i].res : exp_res);
			send_stamp(dir_rows[i].stamp);
		end
		wait_drained();

		stamp = prev_stamp;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p >= NUM_FIXED) begin
				ph_tau[p]  = TAU_W'($urandom_range(10000, 60000000));
				ph_maxi[p] = MAXI_W'($urandom_range(1, 1000000));
			end
			set_config(ph_tau[p], ph_maxi[p]);
			tx_gaps = (p != HOLD_PHASE);
			if (p == HOLD_PHASE)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				stamp = next_stamp(stamp);
				drive_stamp(stamp);
			end
			wait_drained();
		end

		repeat (END_CYCLES) @(posedge clk);
		if (rate_results_q.size() != 0) begin
			err_cnt += rate_results_q.size();
			$display("%0d results never arrived", rate_results_q.size());
		end
		$display("sent %0d timestamps over %0d register settings incl. extremes and one long",
			sent_cnt, NUM_PHASES);
		$display("output hold; checked %0d results (%0d updates), %0d errors",
			checked_cnt, updated_cnt, err_cnt);
		if (err_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/frm_pkg.sv
rtl/core/frm_divider.sv
rtl/core/frm_datapath.sv
rtl/core/frm_ctrl.sv
rtl/core/frame_rate_ema_meter_top.sv
tb/sv/tb_top.sv
